[design/fbpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg - shared types and constants for the block pool allocator
// Widths of the register and payload fields, command and status codes,
// and the sizing of the iterative divider.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int MAX_BLOCKS_DEF = 1024;

   localparam int BSIZE_W   = 16;
   localparam int BCNT_W    = 11;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int OFS_W     = 32;
   localparam int BOFF_W    = 26;

   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 16'd64;
   localparam logic [BCNT_W-1:0]  BCNT_RESET  = 11'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'b1;

   // divider retires this many quotient bits per cycle
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_STEPS     = OFS_W / DIV_STEP_BITS;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } fbpa_cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_MISALIGNED = 3'd2,
      ST_RANGE      = 3'd3,
      ST_DOUBLE     = 3'd4
   } fbpa_status_type;

   typedef struct packed {
      fbpa_cmd_type             cmd;
      logic signed [OFS_W-1:0]  release_offset;
   } fbpa_req_type;

   typedef struct packed {
      fbpa_status_type          status;
      logic [BOFF_W-1:0]        block_offset;
   } fbpa_rsp_type;

   // memory access strobes from the controller to the store
   typedef struct packed {
      logic ring_en;
      logic ring_we;
      logic flag_en;
      logic flag_we;
      logic flag_wdata;
   } fbpa_mem_ctl_type;

endpackage
`default_nettype wire

[design/fbpa_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_stream_if - valid/ready channel
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface fbpa_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/fixed_block_pool_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator - fixed-size block pool allocator
// Ring free list plus one free flag per block, held in on-chip memory.
// ----------------------------------------------------------------------------
// One command is handled at a time and each gives exactly one response beat.
// An allocate goes through the ring read, the flag clear with offset multiply
// and the response register. A release that passes the alignment and range
// checks runs the iterative divider, which retires 4 quotient bits per cycle,
// then the flag read and the ring/flag write-back. A misaligned or
// out-of-range release skips the flag read and the write-back. A release
// with a zero block size and an allocate from an empty pool skip the
// memories and the divider. After reset and after every CSR write the store
// sweeps all MAX_BLOCKS entries, one per cycle, and no command is accepted
// during that sweep. A response waiting on rsp_chan does not block the next
// command from being accepted.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   fbpa_stream_if.sink                               req_chan,
   fbpa_stream_if.source                             rsp_chan,
   input  wire logic                                 csr_we,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [fbpa_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > fbpa_pkg::BCNT_W) ? CNT_W : fbpa_pkg::BCNT_W;

   logic [fbpa_pkg::BSIZE_W-1:0] block_size_ff, block_size_in;
   logic [fbpa_pkg::BCNT_W-1:0]  block_count_ff, block_count_in;
   logic                         refill_ff;

   logic [CMP_W-1:0]             count_w;
   logic [CNT_W-1:0]             pool_n;

   fbpa_pkg::fbpa_mem_ctl_type   mem_ctl;
   logic [IDX_W-1:0]             ring_addr;
   logic [IDX_W-1:0]             ring_wdata;
   logic [IDX_W-1:0]             flag_addr;
   logic [IDX_W-1:0]             ring_rdata;
   logic                         flag_rdata;
   logic                         store_busy;

   logic                         div_start;
   logic [fbpa_pkg::OFS_W-1:0]   div_dividend;
   logic [fbpa_pkg::BSIZE_W-1:0] div_divisor;
   logic                         div_done;
   logic [fbpa_pkg::OFS_W-1:0]   div_quo;
   logic [fbpa_pkg::BSIZE_W-1:0] div_rem;

   always_comb begin
      block_size_in  = block_size_ff;
      block_count_in = block_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            fbpa_pkg::CSR_BLOCK_SIZE:  block_size_in  = csr_wdata;
            fbpa_pkg::CSR_BLOCK_COUNT: block_count_in = csr_wdata[fbpa_pkg::BCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // refill pulse follows reset and every CSR write in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= fbpa_pkg::BSIZE_RESET;
         block_count_ff <= fbpa_pkg::BCNT_RESET;
         refill_ff      <= 1'b1;
      end else begin
         block_size_ff  <= block_size_in;
         block_count_ff <= block_count_in;
         refill_ff      <= csr_we;
      end
   end

   // block counts above the built capacity act as full capacity
   always_comb begin
      count_w = CMP_W'(block_count_ff);
      if (count_w > CMP_W'(MAX_BLOCKS)) begin
         count_w = CMP_W'(MAX_BLOCKS);
      end
      pool_n = CNT_W'(count_w);
   end

   fbpa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   fbpa_store #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .refill     (refill_ff),
      .ctl        (mem_ctl),
      .ring_addr  (ring_addr),
      .ring_wdata (ring_wdata),
      .flag_addr  (flag_addr),
      .ring_rdata (ring_rdata),
      .flag_rdata (flag_rdata),
      .busy       (store_busy)
   );

   fbpa_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .refill       (refill_ff),
      .block_size   (block_size_ff),
      .pool_n       (pool_n),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .mem_ctl      (mem_ctl),
      .ring_addr    (ring_addr),
      .ring_wdata   (ring_wdata),
      .flag_addr    (flag_addr),
      .ring_rdata   (ring_rdata),
      .flag_rdata   (flag_rdata),
      .store_busy   (store_busy),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quo      (div_quo),
      .div_rem      (div_rem)
   );

endmodule
`default_nettype wire

[design/fbpa_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_divider - iterative unsigned divider
// Restoring division of a 32-bit dividend by a 16-bit divisor,
// DIV_STEP_BITS quotient bits per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module fbpa_divider (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [fbpa_pkg::OFS_W-1:0]          dividend,
   input  wire logic [fbpa_pkg::BSIZE_W-1:0]        divisor,
   output logic                                     done,
   output logic [fbpa_pkg::OFS_W-1:0]               quotient,
   output logic [fbpa_pkg::BSIZE_W-1:0]             remainder
);

   localparam int QW = fbpa_pkg::OFS_W;
   localparam int DW = fbpa_pkg::BSIZE_W;

   logic                               run_ff, run_in;
   logic                               done_ff, done_in;
   logic [fbpa_pkg::DIV_CNT_W-1:0]     step_ff, step_in;
   logic [QW-1:0]                      quo_ff, quo_in;
   logic [DW-1:0]                      rem_ff, rem_in;
   logic [DW-1:0]                      dvs_ff, dvs_in;

   logic [QW-1:0]                      q_work;
   logic [DW-1:0]                      r_work;
   logic [DW:0]                        trial;

   // shift-subtract over DIV_STEP_BITS bits
   always_comb begin
      q_work = quo_ff;
      r_work = rem_ff;
      trial  = '0;
      for (int k = 0; k < fbpa_pkg::DIV_STEP_BITS; k++) begin
         trial  = {r_work, q_work[QW-1]};
         q_work = {q_work[QW-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            r_work    = DW'(trial - {1'b0, dvs_ff});
            q_work[0] = 1'b1;
         end else begin
            r_work = trial[DW-1:0];
         end
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (run_ff) begin
         quo_in  = q_work;
         rem_in  = r_work;
         step_in = step_ff + fbpa_pkg::DIV_CNT_W'(1);
         if (step_ff == fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_done_single : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");

endmodule
`default_nettype wire

[design/fbpa_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_store - free ring and free flag memories
// Two single-port synchronous memories with registered read data. After
// reset or a refill request a sweep rewrites every entry: ring entry i
// gets i, every flag is set.
// ----------------------------------------------------------------------------
module fbpa_store #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          refill,
   input  wire fbpa_pkg::fbpa_mem_ctl_type    ctl,
   input  wire logic [$clog2(MAX_BLOCKS)-1:0] ring_addr,
   input  wire logic [$clog2(MAX_BLOCKS)-1:0] ring_wdata,
   input  wire logic [$clog2(MAX_BLOCKS)-1:0] flag_addr,
   output logic [$clog2(MAX_BLOCKS)-1:0]      ring_rdata,
   output logic                               flag_rdata,
   output logic                               busy
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);

   logic [IDX_W-1:0] ring_mem [MAX_BLOCKS];
   logic             flag_mem [MAX_BLOCKS];

   logic             sweep_ff, sweep_in;
   logic [IDX_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [IDX_W-1:0] ring_rdata_ff;
   logic             flag_rdata_ff;

   logic             ring_wr;
   logic [IDX_W-1:0] ring_waddr;
   logic [IDX_W-1:0] ring_wd;
   logic             flag_wr;
   logic [IDX_W-1:0] flag_waddr;
   logic             flag_wd;

   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      if (refill) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
      end else if (sweep_ff) begin
         if (sweep_addr_ff == IDX_W'(MAX_BLOCKS - 1)) begin
            sweep_in = 1'b0;
         end else begin
            sweep_addr_in = sweep_addr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   always_comb begin
      ring_wr    = sweep_ff || (ctl.ring_en && ctl.ring_we);
      ring_waddr = sweep_ff ? sweep_addr_ff : ring_addr;
      ring_wd    = sweep_ff ? sweep_addr_ff : ring_wdata;
      flag_wr    = sweep_ff || (ctl.flag_en && ctl.flag_we);
      flag_waddr = sweep_ff ? sweep_addr_ff : flag_addr;
      flag_wd    = sweep_ff ? 1'b1 : ctl.flag_wdata;
   end

   always_ff @(posedge clock) begin
      if (ring_wr) begin
         ring_mem[ring_waddr] <= ring_wd;
      end
      if (ctl.ring_en && !ctl.ring_we) begin
         ring_rdata_ff <= ring_mem[ring_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (flag_wr) begin
         flag_mem[flag_waddr] <= flag_wd;
      end
      if (ctl.flag_en && !ctl.flag_we) begin
         flag_rdata_ff <= flag_mem[flag_addr];
      end
   end

   assign ring_rdata = ring_rdata_ff;
   assign flag_rdata = flag_rdata_ff;
   assign busy       = sweep_ff;

   a_sweep_from_refill : assert property (@(posedge clock) disable iff (reset)
      (!sweep_ff && !refill) |=> !sweep_ff)
      else $error("store sweep started without a refill request");

endmodule
`default_nettype wire

[design/fbpa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_ctrl - allocate/release sequencer
// Takes one command at a time, keeps ring head, tail and free count, drives
// the store and the divider, and holds the result in an output register.
// ----------------------------------------------------------------------------
module fbpa_ctrl #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                refill,
   input  wire logic [fbpa_pkg::BSIZE_W-1:0]        block_size,
   input  wire logic [$clog2(MAX_BLOCKS+1)-1:0]     pool_n,
   fbpa_stream_if.sink                              req_chan,
   fbpa_stream_if.source                            rsp_chan,
   output fbpa_pkg::fbpa_mem_ctl_type               mem_ctl,
   output logic [$clog2(MAX_BLOCKS)-1:0]            ring_addr,
   output logic [$clog2(MAX_BLOCKS)-1:0]            ring_wdata,
   output logic [$clog2(MAX_BLOCKS)-1:0]            flag_addr,
   input  wire logic [$clog2(MAX_BLOCKS)-1:0]       ring_rdata,
   input  wire logic                                flag_rdata,
   input  wire logic                                store_busy,
   output logic                                     div_start,
   output logic [fbpa_pkg::OFS_W-1:0]               div_dividend,
   output logic [fbpa_pkg::BSIZE_W-1:0]             div_divisor,
   input  wire logic                                div_done,
   input  wire logic [fbpa_pkg::OFS_W-1:0]          div_quo,
   input  wire logic [fbpa_pkg::BSIZE_W-1:0]        div_rem
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int PROD_W = IDX_W + fbpa_pkg::BSIZE_W;
   localparam int OFS_W  = fbpa_pkg::OFS_W;
   localparam int BOFF_W = fbpa_pkg::BOFF_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_RD,
      S_DIV,
      S_REL_RD,
      S_FINISH
   } ctrl_state_type;

   ctrl_state_type             state_ff, state_in;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic [IDX_W-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       neg_ff, neg_in;
   logic [IDX_W-1:0]           pos_ff, pos_in;
   fbpa_pkg::fbpa_status_type  res_status_ff, res_status_in;
   logic [BOFF_W-1:0]          res_offset_ff, res_offset_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   fbpa_pkg::fbpa_status_type  rsp_status_ff, rsp_status_in;
   logic [BOFF_W-1:0]          rsp_offset_ff, rsp_offset_in;

   logic                       req_ready;
   logic                       accept;
   logic [OFS_W-1:0]           raw;
   logic [OFS_W-1:0]           mag;
   logic [PROD_W-1:0]          prod;
   logic [IDX_W-1:0]           head_next;
   logic [IDX_W-1:0]           tail_next;

   assign req_ready = (state_ff == S_IDLE) && !store_busy && !refill;
   assign accept    = req_chan.valid && req_ready;

   // two's complement magnitude; the most negative value stays 2^31
   assign raw  = req_chan.payload.release_offset;
   assign mag  = raw[OFS_W-1] ? (~raw + OFS_W'(1)) : raw;

   assign prod = PROD_W'(ring_rdata) * PROD_W'(block_size);

   // ring pointers wrap at the pool size
   assign head_next = (CNT_W'(head_ff) + CNT_W'(1) == pool_n) ? '0 : head_ff + IDX_W'(1);
   assign tail_next = (CNT_W'(tail_ff) + CNT_W'(1) == pool_n) ? '0 : tail_ff + IDX_W'(1);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      neg_in        = neg_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;

      mem_ctl       = '0;
      ring_addr     = head_ff;
      ring_wdata    = pos_ff;
      flag_addr     = pos_ff;
      div_start     = 1'b0;
      div_dividend  = mag;
      div_divisor   = block_size;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_offset_in = '0;
               if (req_chan.payload.cmd == fbpa_pkg::CMD_ALLOC) begin
                  if (count_ff == '0 || pool_n == '0) begin
                     res_status_in = fbpa_pkg::ST_EMPTY;
                     state_in      = S_FINISH;
                  end else begin
                     mem_ctl.ring_en = 1'b1;
                     state_in        = S_ALLOC_RD;
                  end
               end else begin
                  neg_in = raw[OFS_W-1];
                  if (block_size == '0) begin
                     res_status_in = fbpa_pkg::ST_MISALIGNED;
                     state_in      = S_FINISH;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
            end
         end
         S_ALLOC_RD: begin
            mem_ctl.flag_en    = 1'b1;
            mem_ctl.flag_we    = 1'b1;
            mem_ctl.flag_wdata = 1'b0;
            flag_addr          = ring_rdata;
            res_status_in      = fbpa_pkg::ST_OK;
            res_offset_in      = BOFF_W'(prod);
            head_in            = head_next;
            count_in           = count_ff - CNT_W'(1);
            state_in           = S_FINISH;
         end
         S_DIV: begin
            if (div_done) begin
               if (div_rem != '0) begin
                  res_status_in = fbpa_pkg::ST_MISALIGNED;
                  state_in      = S_FINISH;
               end else if (neg_ff || div_quo >= OFS_W'(pool_n)) begin
                  res_status_in = fbpa_pkg::ST_RANGE;
                  state_in      = S_FINISH;
               end else begin
                  pos_in          = div_quo[IDX_W-1:0];
                  flag_addr       = div_quo[IDX_W-1:0];
                  mem_ctl.flag_en = 1'b1;
                  state_in        = S_REL_RD;
               end
            end
         end
         S_REL_RD: begin
            if (flag_rdata) begin
               res_status_in = fbpa_pkg::ST_DOUBLE;
            end else begin
               mem_ctl.ring_en    = 1'b1;
               mem_ctl.ring_we    = 1'b1;
               ring_addr          = tail_ff;
               mem_ctl.flag_en    = 1'b1;
               mem_ctl.flag_we    = 1'b1;
               mem_ctl.flag_wdata = 1'b1;
               tail_in            = tail_next;
               count_in           = count_ff + CNT_W'(1);
               res_status_in      = fbpa_pkg::ST_OK;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_offset_in = res_offset_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (refill) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = pool_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff        <= neg_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign req_chan.ready                = req_ready;
   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.payload.status       = rsp_status_ff;
   assign rsp_chan.payload.block_offset = rsp_offset_ff;

   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted command did not start a sequence");

   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside the finish step");

endmodule
`default_nettype wire

[bench/tb_fixed_block_pool_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator - self-checking bench for the block pool
// Drives allocate/release beats with random gaps and random response stalls.
// A local model of the free ring and free flags predicts every response.
// The pool is reconfigured between phases, including empty, oversized and
// zero-size pools, and each response is compared field by field.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator;

   localparam int          POOL_CAP    = fbpa_pkg::MAX_BLOCKS_DEF;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int          RAND_PHASES = 12;
   localparam int          PHASE_ITEMS = 146;

   logic clock = 1'b0;
   logic reset;
   logic                           csr_we;
   logic [fbpa_pkg::CSR_IDX_W-1:0] csr_index;
   logic [fbpa_pkg::CSR_W-1:0]     csr_wdata;

   fbpa_stream_if #(.payload_type(fbpa_pkg::fbpa_req_type)) req_if ();
   fbpa_stream_if #(.payload_type(fbpa_pkg::fbpa_rsp_type)) rsp_if ();

   fixed_block_pool_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // pool model state
   logic [9:0]                   slot_blk [0:POOL_CAP-1];
   bit                           blk_free [0:POOL_CAP-1];
   int                           take_ptr;
   int                           give_ptr;
   int                           avail_cnt;
   logic [fbpa_pkg::BSIZE_W-1:0] cfg_bsize;
   logic [fbpa_pkg::BCNT_W-1:0]  cfg_bcount;

   fbpa_pkg::fbpa_req_type pending_reqs [$];
   fbpa_pkg::fbpa_rsp_type expected_rsps [$];

   int          error_count = 0;
   int unsigned cycle_count = 0;
   int          req_gap = 0;
   int          req_calm = 0;
   int          rsp_stall = 0;
   int          rsp_calm = 0;

   // counts above the built capacity behave as the capacity
   function automatic int pool_len();
      return (cfg_bcount > POOL_CAP) ? POOL_CAP : int'(cfg_bcount);
   endfunction

   function automatic void pool_refill();
      int n;
      n = pool_len();
      for (int i = 0; i < POOL_CAP; i++) begin
         slot_blk[i] = 10'(i);
         blk_free[i] = (i < n);
      end
      take_ptr  = 0;
      give_ptr  = 0;
      avail_cnt = n;
   endfunction

   function automatic fbpa_pkg::fbpa_rsp_type pool_step(fbpa_pkg::fbpa_req_type r);
      fbpa_pkg::fbpa_rsp_type rsp;
      int                     n;
      bit                     neg;
      logic [9:0]             blk;
      longint unsigned        mag;
      longint unsigned        pos;
      longint unsigned        prod;
      n = pool_len();
      rsp.status       = fbpa_pkg::ST_OK;
      rsp.block_offset = '0;
      if (r.cmd == fbpa_pkg::CMD_ALLOC) begin
         if (avail_cnt == 0 || n == 0) begin
            rsp.status = fbpa_pkg::ST_EMPTY;
         end else begin
            blk = slot_blk[take_ptr];
            blk_free[blk] = 1'b0;
            avail_cnt--;
            take_ptr = (take_ptr + 1) % n;
            prod = longint'(blk) * longint'(cfg_bsize);
            rsp.block_offset = prod[fbpa_pkg::BOFF_W-1:0];
         end
      end else begin
         // magnitude of the signed offset; the most negative value stays 2^31
         neg = r.release_offset[fbpa_pkg::OFS_W-1];
         mag = {32'b0, r.release_offset};
         if (neg)
            mag = 64'h1_0000_0000 - mag;
         if (cfg_bsize == 0 || (mag % cfg_bsize) != 0) begin
            rsp.status = fbpa_pkg::ST_MISALIGNED;
         end else begin
            pos = mag / cfg_bsize;
            if (neg || pos >= n) begin
               rsp.status = fbpa_pkg::ST_RANGE;
            end else if (blk_free[pos]) begin
               rsp.status = fbpa_pkg::ST_DOUBLE;
            end else begin
               slot_blk[give_ptr] = 10'(pos);
               blk_free[pos] = 1'b1;
               give_ptr = (give_ptr + 1) % n;
               avail_cnt++;
            end
         end
      end
      return rsp;
   endfunction

   // mostly back-to-back or short gaps, a few long ones, and calm stretches
   function automatic int pick_gap(ref int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void add_req(fbpa_pkg::fbpa_cmd_type c,
                                   logic [fbpa_pkg::OFS_W-1:0] ofs);
      fbpa_pkg::fbpa_req_type r;
      r.cmd            = c;
      r.release_offset = ofs;
      pending_reqs.push_back(r);
   endfunction

   // release offsets: mostly blocks of the pool, some past the end,
   // negative, slightly off alignment or fully random
   function automatic logic [fbpa_pkg::OFS_W-1:0] pick_release();
      int                          n;
      int                          r;
      int unsigned                 idx;
      logic [fbpa_pkg::OFS_W-1:0]  v;
      n = pool_len();
      r = $urandom_range(0, 99);
      if (r < 75) begin
         idx = (n == 0) ? 0 : $urandom_range(0, n - 1);
         return 32'(idx * cfg_bsize);
      end
      if (r < 83)
         return 32'((n + $urandom_range(0, 3)) * cfg_bsize);
      if (r < 90) begin
         v = 32'($urandom_range(1, n + 1) * cfg_bsize);
         return -v;
      end
      if (r < 95) begin
         idx = (n == 0) ? 0 : $urandom_range(0, n - 1);
         return 32'(idx * cfg_bsize + $urandom_range(1, 3));
      end
      return $urandom;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40)
         $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic write_reg(input logic [fbpa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fbpa_pkg::CSR_W-1:0]     value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == fbpa_pkg::CSR_BLOCK_SIZE)
         cfg_bsize = value[fbpa_pkg::BSIZE_W-1:0];
      else
         cfg_bcount = value[fbpa_pkg::BCNT_W-1:0];
      pool_refill();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_rsps.push_back(pool_step(req_if.payload));
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_if.payload <= pending_reqs.pop_front();
               req_if.valid   <= 1'b1;
               req_gap = pick_gap(req_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_stall = pick_gap(rsp_calm);
      end
   end

   // response monitor
   always @(posedge clock) begin
      fbpa_pkg::fbpa_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch($sformatf("unexpected beat: status %0d offset 0x%0h",
                                      rsp_if.payload.status, rsp_if.payload.block_offset));
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_if.payload.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_if.payload.status, want.status));
            if (rsp_if.payload.block_offset !== want.block_offset)
               report_mismatch($sformatf("block_offset 0x%0h, expected 0x%0h",
                                         rsp_if.payload.block_offset, want.block_offset));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_fixed_block_pool_allocator: FAIL");
         $finish;
      end
   end

   initial begin
      logic [fbpa_pkg::BSIZE_W-1:0] bsz;
      logic [fbpa_pkg::BCNT_W-1:0]  cnt;
      int                           alloc_pct;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      cfg_bsize      = fbpa_pkg::BSIZE_RESET;
      cfg_bcount     = fbpa_pkg::BCNT_RESET;
      pool_refill();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // default pool: alloc, release checks in order, sign corner cases
      add_req(fbpa_pkg::CMD_ALLOC, '0);
      add_req(fbpa_pkg::CMD_ALLOC, '1);
      add_req(fbpa_pkg::CMD_ALLOC, '0);
      add_req(fbpa_pkg::CMD_RELEASE, 32'd64);
      add_req(fbpa_pkg::CMD_RELEASE, 32'd64);
      add_req(fbpa_pkg::CMD_RELEASE, 32'd65);
      add_req(fbpa_pkg::CMD_RELEASE, 32'd65536);
      add_req(fbpa_pkg::CMD_RELEASE, -32'sd64);
      add_req(fbpa_pkg::CMD_RELEASE, -32'sd1);
      add_req(fbpa_pkg::CMD_RELEASE, 32'h8000_0000);
      add_req(fbpa_pkg::CMD_RELEASE, 32'h7FFF_FFFF);
      add_req(fbpa_pkg::CMD_RELEASE, 32'd0);
      wait_idle();

      // two blocks of the largest size: drain to empty, free one, reuse it
      write_reg(fbpa_pkg::CSR_BLOCK_SIZE, 16'hFFFF);
      write_reg(fbpa_pkg::CSR_BLOCK_COUNT, 16'd2);
      repeat (3) add_req(fbpa_pkg::CMD_ALLOC, '0);
      add_req(fbpa_pkg::CMD_RELEASE, 32'h0000_FFFF);
      add_req(fbpa_pkg::CMD_ALLOC, '0);
      wait_idle();

      // empty pool
      write_reg(fbpa_pkg::CSR_BLOCK_COUNT, 16'd0);
      add_req(fbpa_pkg::CMD_ALLOC, '0);
      add_req(fbpa_pkg::CMD_RELEASE, 32'd0);
      wait_idle();

      // zero block size, count above capacity
      write_reg(fbpa_pkg::CSR_BLOCK_SIZE, 16'd0);
      write_reg(fbpa_pkg::CSR_BLOCK_COUNT, 16'hFFFF);
      add_req(fbpa_pkg::CMD_ALLOC, '0);
      add_req(fbpa_pkg::CMD_RELEASE, 32'd0);
      wait_idle();

      write_reg(fbpa_pkg::CSR_BLOCK_SIZE, 16'd1);
      add_req(fbpa_pkg::CMD_ALLOC, '0);
      add_req(fbpa_pkg::CMD_RELEASE, 32'd1);
      add_req(fbpa_pkg::CMD_RELEASE, 32'd0);

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         wait_idle();
         case ($urandom_range(0, 7))
            0:       bsz = 16'hFFFF;
            1:       bsz = 16'd1;
            2, 3:    bsz = 16'd1 << $urandom_range(0, 15);
            default: bsz = 16'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 9))
            0:       cnt = 11'd1024;
            1:       cnt = 11'($urandom_range(1, 1024));
            2:       cnt = 11'($urandom_range(1025, 2047));
            default: cnt = 11'($urandom_range(1, 12));
         endcase
         write_reg(fbpa_pkg::CSR_BLOCK_SIZE, bsz);
         write_reg(fbpa_pkg::CSR_BLOCK_COUNT, {5'($urandom), cnt});
         alloc_pct = 50;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // swing between filling and draining the pool
            if (i % 20 == 0)
               alloc_pct = $urandom_range(20, 80);
            if ($urandom_range(0, 99) < alloc_pct)
               add_req(fbpa_pkg::CMD_ALLOC, $urandom);
            else
               add_req(fbpa_pkg::CMD_RELEASE, pick_release());
         end
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("tb_fixed_block_pool_allocator: PASS");
      else
         $display("tb_fixed_block_pool_allocator: FAIL");
      $finish;
   end

endmodule
`default_nettype wire
